/* rtl/rpc_pkg.sv */
// Shared types and constants of the RNA pair constraint checker.
package rpc_pkg;

   localparam int POS_W   = 10;          // width of a sequence position
   localparam int LEN_W   = 11;          // width of a length or scan count
   localparam int EXT_W   = 17;          // common width for compares against the table depth
   localparam int ENTRY_W = POS_W + 1;   // stored entry: unpair flag over partner
   localparam int OP_W    = 2;
   localparam int CSR_IDX_W = 4;

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 8;

   localparam int REQ_I_LSB  = 0;
   localparam int REQ_J_LSB  = 10;
   localparam int REQ_K_LSB  = 20;
   localparam int REQ_L_LSB  = 30;
   localparam int REQ_PV_LSB = 40;
   localparam int REQ_UF_BIT = 50;

   localparam logic [CSR_IDX_W-1:0] CSR_CONSTRAINTS_ON = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEQ_LENGTH     = 4'd1;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD = 2'd0,
      OP_QUAD = 2'd1,
      OP_PAIR = 2'd2,
      OP_NONE = 2'd3
   } rpc_op_type;

   // Query positions handed to the scan datapath when a request is accepted.
   typedef struct packed {
      logic [POS_W-1:0] pos_i;
      logic [POS_W-1:0] pos_j;
      logic [POS_W-1:0] pos_k;
      logic [POS_W-1:0] pos_l;
      logic [POS_W-1:0] pos_x;    // lower of i and j
      logic [POS_W-1:0] pos_y;    // higher of i and j
      logic             y_valid;  // higher end lies inside the sequence
   } rpc_query_type;

   // Per-cycle control of the scan datapath.
   typedef struct packed {
      logic             start;    // load a new query and clear the flags
      logic             valid;    // read data of table entry pos is present
      logic [LEN_W-1:0] pos;
   } rpc_beat_type;

endpackage

/* rtl/rpc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module rpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/rpc_scan.sv */
// Scan datapath: folds each table entry read into the query's conflict flags.
module rpc_scan
   import rpc_pkg::*;
(
   input  logic               clock,
   input  rpc_beat_type       beat,
   input  rpc_query_type      query,
   input  logic [ENTRY_W-1:0] rd_data,
   output logic               conflict,
   output logic               allowed
);

   rpc_query_type    q_ff, q_in;
   logic [POS_W-1:0] pi_ff, pi_in, pj_ff, pj_in;
   logic             ui_ff, ui_in, uj_ff, uj_in;
   logic             cross_ff, cross_in, inner_ff, inner_in;

   logic [LEN_W-1:0] a, b, xi, yi, ii, ji, ki, li;
   logic             u, hit_cross, hit_inner;

   always_comb begin
      a  = beat.pos;
      b  = LEN_W'(rd_data[POS_W-1:0]);
      u  = rd_data[POS_W];
      xi = LEN_W'(q_ff.pos_x);
      yi = LEN_W'(q_ff.pos_y);
      ii = LEN_W'(q_ff.pos_i);
      ji = LEN_W'(q_ff.pos_j);
      ki = LEN_W'(q_ff.pos_k);
      li = LEN_W'(q_ff.pos_l);

      // A forced pair a<b crosses x,y when exactly one of its ends lies between them.
      hit_cross = q_ff.y_valid && (b > a) &&
                  (((xi < a) && (a < yi) && (yi < b)) || ((a < xi) && (xi < b) && (b < yi)));
      // A paired position strictly inside one of the two inner loops.
      hit_inner = (b != a) && (((ii < a) && (a < ki)) || ((li < a) && (a < ji)));

      q_in     = q_ff;
      pi_in    = pi_ff;
      pj_in    = pj_ff;
      ui_in    = ui_ff;
      uj_in    = uj_ff;
      cross_in = cross_ff;
      inner_in = inner_ff;

      if (beat.start) begin
         // Positions not reached by the scan keep themselves as partner.
         q_in     = query;
         pi_in    = query.pos_i;
         pj_in    = query.pos_j;
         ui_in    = 1'b0;
         uj_in    = 1'b0;
         cross_in = 1'b0;
         inner_in = 1'b0;
      end else if (beat.valid) begin
         if (a == ii) begin
            pi_in = rd_data[POS_W-1:0];
            ui_in = u;
         end
         if (a == ji) begin
            pj_in = rd_data[POS_W-1:0];
            uj_in = u;
         end
         cross_in = cross_ff | hit_cross;
         inner_in = inner_ff | hit_inner;
      end
   end

   always_ff @(posedge clock) begin
      q_ff     <= q_in;
      pi_ff    <= pi_in;
      pj_ff    <= pj_in;
      ui_ff    <= ui_in;
      uj_ff    <= uj_in;
      cross_ff <= cross_in;
      inner_ff <= inner_in;
   end

   assign conflict = (((pi_ff != q_ff.pos_i) || (pj_ff != q_ff.pos_j)) && (pi_ff != q_ff.pos_j))
                     || cross_ff || inner_ff;
   assign allowed  = !(ui_ff || uj_ff) &&
                     ((pi_ff == q_ff.pos_j) || ((pi_ff == q_ff.pos_i) && (pj_ff == q_ff.pos_j)));

endmodule

/* rtl/rna_pair_constraint_checker.sv */
// Top level of the RNA pair constraint checker: control, configuration and table memory.
//
//   Channel  Direction  Handshake                Content
//   req_     in         req_tvalid / req_tready  tuser: operation; tdata: positions, load data
//   rsp_     out        rsp_tvalid / rsp_tready  tuser: echoed operation; tdata: answer
//   csr_     in         csr_valid / csr_ready    csr_index selects the register, csr_data value
//
// A load, an unknown operation, or any query while constraints are off or the effective
// sequence length is zero goes straight to the finish state.
// A quad or pair query with constraints on scans L entries, L being the effective
// sequence length: the scan reads the partner table one entry per cycle through the
// single read port of the memory, so the table scan sets the rate.
// Reset is synchronous and clears the control state and both registers; the table
// contents are not cleared and must be loaded before they are used.
// The output register holds one request's result while the next request is accepted;
// a finished result waits in its last state while the output register is still full.
module rna_pair_constraint_checker
   import rpc_pkg::*;
#(
   parameter int MAX_LEN = 1024
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   // Bits from the lowest up: pos_i[9:0], pos_j[19:10], pos_k[29:20], pos_l[39:30],
   // partner_value[49:40], unpair_flag[50], zero fill[55:51].
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // Bits: operation[1:0].
   input  logic [OP_W-1:0]        req_tuser,

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // Bits from the lowest up: answer[0], zero fill[7:1].
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // Bits: answer_kind[1:0].
   output logic [OP_W-1:0]        rsp_tuser,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [LEN_W-1:0]       csr_data
);

   localparam int AW = $clog2(MAX_LEN);
   localparam logic [EXT_W-1:0] MaxLenExt = EXT_W'(MAX_LEN);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // Configuration registers.
   logic             cfg_on_ff;
   logic [LEN_W-1:0] cfg_len_ff;

   // Control state and registered outputs.
   state_type        state_ff, state_in;
   logic [LEN_W-1:0] cnt_ff, cnt_in;
   logic [LEN_W-1:0] scan_len_ff, scan_len_in;
   rpc_op_type       op_ff, op_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_answer_ff, rsp_answer_in;
   rpc_op_type       rsp_kind_ff, rsp_kind_in;

   // Read pipeline alongside the memory's registered read.
   logic             rd_valid_ff;
   logic [LEN_W-1:0] rd_pos_ff;

   logic             req_accept;
   rpc_op_type       req_op;
   logic [POS_W-1:0] req_i, req_j, req_k, req_l, req_pv;
   logic             req_uf;
   logic [LEN_W-1:0] eff_len;
   logic [EXT_W-1:0] wr_addr_ext, rd_addr_ext;
   logic             wr_en;
   logic [ENTRY_W-1:0] rd_data;
   rpc_query_type    query;
   rpc_beat_type     beat;
   logic             conflict, allowed, answer_sel, out_free;

   assign req_op = rpc_op_type'(req_tuser);
   assign req_i  = req_tdata[REQ_I_LSB  +: POS_W];
   assign req_j  = req_tdata[REQ_J_LSB  +: POS_W];
   assign req_k  = req_tdata[REQ_K_LSB  +: POS_W];
   assign req_l  = req_tdata[REQ_L_LSB  +: POS_W];
   assign req_pv = req_tdata[REQ_PV_LSB +: POS_W];
   assign req_uf = req_tdata[REQ_UF_BIT];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // Lengths above the table depth act as the depth.
   assign eff_len = (EXT_W'(cfg_len_ff) < MaxLenExt) ? cfg_len_ff : MaxLenExt[LEN_W-1:0];

   // Configuration writes are always taken; unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_on_ff  <= 1'b0;
         cfg_len_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CONSTRAINTS_ON: cfg_on_ff  <= csr_data[0];
            CSR_SEQ_LENGTH:     cfg_len_ff <= csr_data;
            default:            ;
         endcase
      end
   end

   // Loads write the table at once on acceptance; positions beyond the depth are ignored.
   assign wr_addr_ext = EXT_W'(req_i);
   assign wr_en       = req_accept && (req_op == OP_LOAD) && (wr_addr_ext < MaxLenExt);
   assign rd_addr_ext = EXT_W'(cnt_ff);

   rpc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_LEN)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr_ext[AW-1:0]),
      .wr_data ({req_uf, req_pv}),
      .rd_addr (rd_addr_ext[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      query.pos_i   = req_i;
      query.pos_j   = req_j;
      query.pos_k   = req_k;
      query.pos_l   = req_l;
      query.pos_x   = (req_i < req_j) ? req_i : req_j;
      query.pos_y   = (req_i < req_j) ? req_j : req_i;
      query.y_valid = (LEN_W'(query.pos_y) < eff_len);

      beat.start = req_accept;
      beat.valid = rd_valid_ff;
      beat.pos   = rd_pos_ff;
   end

   rpc_scan u_scan (
      .clock    (clock),
      .beat     (beat),
      .query    (query),
      .rd_data  (rd_data),
      .conflict (conflict),
      .allowed  (allowed)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= (state_ff == ST_SCAN);
      end
      rd_pos_ff <= cnt_ff;
   end

   always_comb begin
      case (op_ff)
         OP_QUAD: answer_sel = conflict;
         OP_PAIR: answer_sel = allowed;
         default: answer_sel = 1'b0;
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      scan_len_in   = scan_len_ff;
      op_in         = op_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_answer_in = rsp_answer_ff;
      rsp_kind_in   = rsp_kind_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in       = req_op;
               cnt_in      = '0;
               // With constraints off the untouched defaults already give the answer.
               scan_len_in = cfg_on_ff ? eff_len : '0;
               if (((req_op == OP_QUAD) || (req_op == OP_PAIR)) && (scan_len_in != '0)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + LEN_W'(1);
            if (cnt_ff == scan_len_ff - LEN_W'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_answer_in = answer_sel;
               rsp_kind_in   = op_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         scan_len_ff  <= '0;
         op_ff        <= OP_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         scan_len_ff   <= scan_len_in;
         op_ff         <= op_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_answer_ff <= rsp_answer_in;
         rsp_kind_ff   <= rsp_kind_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-1){1'b0}}, rsp_answer_ff};
   assign rsp_tuser  = rsp_kind_ff;

endmodule
